[hw/rtl/sst_pkg.sv]
// Shared types and constants for the small set table.
// Used by sst_ctrl, small_set_table_core and sst_checker. No dependencies.
`default_nettype none

package sst_pkg;

    // Default number of slots in the element store.
    localparam int DEFAULT_CAPACITY = 128;

    // Element width and packed stream widths.
    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Request kinds. The unused code is served as a lookup.
    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_NOCHG = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    // One result item as handed from the sequencer to the output register.
    typedef struct packed {
        t_status     status;
        logic [7:0]  entry_count;
        logic [6:0]  position;
        logic        found;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/small_set_table_core.sv]
// Small set table: distinct signed 32-bit values kept in insertion order.
//
// Slave channel (i_s_*): one request item per handshake, kind 0 lookup,
// 1 insert, 2 remove (3 is served as a lookup), plus the value.
// Master channel (o_m_*): one result item per request with found, position,
// entry count after the request, and status (0 done, 1 no change, 2 full).
// The block works on one item at a time. The search reads the element RAM
// one slot at a time, a read state then a compare state per slot, up to the
// found slot or, if the value is absent, through every entry. A remove then
// shifts every later entry down one slot, with a read and a write state each;
// reads and shifts together never pass the entry count. The single RAM port
// pair sets this serial schedule. The result leaves the sequencer once the
// output register is free, and then shows on the master channel in the same
// cycle as the next request can be taken.
// The result sits in an output register; the next request is taken while it
// waits, and when the receiver stalls the sequencer holds its finished
// result until the register is free.
// Reset (synchronous, active low) empties the set at once; no clearing pass.
// Depends on sst_pkg, sst_ram and sst_ctrl.
`default_nettype none

module small_set_table_core #(
    parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request items: [1:0] kind, [33:2] value, [39:34] zero.
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [sst_pkg::S_TDATA_W-1:0] i_s_tdata,
    // Result items: [0] found, [7:1] position, [15:8] entry_count,
    // [17:16] status, [23:18] zero.
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [sst_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import sst_pkg::*;

    localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                 r_out_valid, n_out_valid;
    t_result              r_out_data, n_out_data;

    logic                 w_res_valid;
    logic                 w_res_ready;
    t_result              w_res;
    logic                 w_rd_en;
    logic [AddrW-1:0]     w_rd_addr;
    logic [VALUE_W-1:0]   w_rd_data;
    logic                 w_wr_en;
    logic [AddrW-1:0]     w_wr_addr;
    logic [VALUE_W-1:0]   w_wr_data;

    sst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_kind      (i_s_tdata[1:0]),
        .i_value     (i_s_tdata[33:2]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    sst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: free when empty or being drained this cycle.
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_res_ready) begin
            n_out_valid = w_res_valid;
            if (w_res_valid) begin
                n_out_data = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_out_data};

endmodule

`default_nettype wire

[hw/rtl/sst_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AddrW-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AddrW-1:0] i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sst_ctrl.sv]
// Sequencer of the small set table: linear search, append and compaction shift
// over the element RAM. Depends on sst_pkg.
`default_nettype none

module sst_ctrl #(
    parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY,
    localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CntW  = $clog2(CAPACITY + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Request side
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [sst_pkg::VALUE_W-1:0] i_value,
    // Result side
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output sst_pkg::t_result                o_res,
    // Element RAM
    output logic                            o_rd_en,
    output logic [AddrW-1:0]                o_rd_addr,
    input  wire logic [sst_pkg::VALUE_W-1:0] i_rd_data,
    output logic                            o_wr_en,
    output logic [AddrW-1:0]                o_wr_addr,
    output logic [sst_pkg::VALUE_W-1:0]     o_wr_data
);
    import sst_pkg::*;

    t_state               r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [CntW-1:0]      r_count, n_count;
    logic [CntW-1:0]      r_idx, n_idx;
    logic [CntW-1:0]      r_slot, n_slot;
    logic                 r_hit, n_hit;
    t_status              r_status, n_status;

    logic [CntW:0]        w_idx_inc;
    logic [CntW:0]        w_idx_inc2;
    logic [CntW:0]        w_slot_inc;
    logic                 w_match;
    logic                 w_full;
    logic                 w_shift;
    logic                 w_append;

    // Index arithmetic, one bit wider so that the end compare cannot wrap.
    assign w_idx_inc  = {1'b0, r_idx} + 1'b1;
    assign w_idx_inc2 = {1'b0, r_idx} + 2'd2;
    assign w_slot_inc = {1'b0, r_slot} + 1'b1;
    assign w_match    = (i_rd_data == r_value);
    assign w_full     = (r_count >= CntW'(CAPACITY));
    assign w_shift    = (r_kind == KIND_REMOVE) && r_hit && (w_slot_inc < {1'b0, r_count});
    assign w_append   = (r_kind == KIND_INSERT) && !r_hit && !w_full;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_count == '0) ? S_DECIDE : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match || (w_idx_inc >= {1'b0, r_count})) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DECIDE: begin
                n_state = w_shift ? S_SH_RD : S_DONE;
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                n_state = (w_idx_inc2 < {1'b0, r_count}) ? S_SH_RD : S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath registers: request, search position, count and status.
    always_comb begin
        n_kind   = r_kind;
        n_value  = r_value;
        n_count  = r_count;
        n_idx    = r_idx;
        n_slot   = r_slot;
        n_hit    = r_hit;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = t_kind'(i_kind);
                    n_value = i_value;
                    n_idx   = '0;
                    n_slot  = '0;
                    n_hit   = 1'b0;
                end
            end
            S_CMP: begin
                if (w_match) begin
                    n_hit  = 1'b1;
                    n_slot = r_idx;
                end else begin
                    n_idx = w_idx_inc[CntW-1:0];
                end
            end
            S_DECIDE: begin
                case (r_kind)
                    KIND_INSERT: begin
                        if (r_hit) begin
                            n_status = STATUS_NOCHG;
                        end else if (w_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_status = STATUS_DONE;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_hit) begin
                            n_status = STATUS_DONE;
                            n_idx    = r_slot;
                            if (!w_shift) begin
                                n_count = r_count - 1'b1;
                            end
                        end else begin
                            n_status = STATUS_NOCHG;
                        end
                    end
                    default: begin
                        n_status = r_hit ? STATUS_DONE : STATUS_NOCHG;
                    end
                endcase
            end
            S_SH_WR: begin
                n_idx = w_idx_inc[CntW-1:0];
                if (w_idx_inc2 >= {1'b0, r_count}) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Outputs: handshakes and RAM accesses.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_rd_en     = (r_state == S_RD) || (r_state == S_SH_RD);
        o_rd_addr   = (r_state == S_SH_RD) ? w_idx_inc[AddrW-1:0] : r_idx[AddrW-1:0];
        o_wr_en     = ((r_state == S_DECIDE) && w_append) || (r_state == S_SH_WR);
        o_wr_addr   = (r_state == S_SH_WR) ? r_idx[AddrW-1:0] : r_count[AddrW-1:0];
        o_wr_data   = (r_state == S_SH_WR) ? i_rd_data : r_value;
        o_res.found       = r_hit;
        o_res.position    = 7'(r_slot);
        o_res.entry_count = 8'(r_count);
        o_res.status      = r_status;
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_slot   <= n_slot;
        r_hit    <= n_hit;
        r_status <= n_status;
    end

endmodule

`default_nettype wire

[hw/rtl/sst_checker.sv]
// Port-level checks for small_set_table_core, attached by a bind statement.
// Depends on sst_pkg and small_set_table_core.
`default_nettype none

module sst_checker #(
    parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [sst_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import sst_pkg::*;

    // No result item is offered right after a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    // A stalled result item holds its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // A miss reports slot zero.
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[7:1] == 7'd0)
        else $error("miss with nonzero position");

    // A full rejection only comes from a miss on a store at capacity.
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[17:16] == STATUS_FULL)
        |-> !o_m_tdata[0] && (o_m_tdata[15:8] == 8'(CAPACITY)))
        else $error("full status with inconsistent fields");

    // The status code is always a defined one.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[17:16] != 2'd3)
        else $error("undefined status code");

endmodule

bind small_set_table_core sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);

`default_nettype wire
